>>> src/per_cpu_page_free_lists_macros.svh
// Assertion macros shared by the per-CPU page free list RTL.
`ifndef PER_CPU_PAGE_FREE_LISTS_MACROS_SVH
`define PER_CPU_PAGE_FREE_LISTS_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on aclk, with the check held off while aresetn is low.
`define PCPFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on aclk, including the edges at which reset is applied.
`define PCPFL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PCPFL_ASSERT(lbl, prop, msg)
`define PCPFL_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> src/pcpfl_pkg.sv
// Constants and codes shared by the per-CPU page free list block.
package pcpfl_pkg;

    localparam int ADDR_W     = 40;
    localparam int PAGE_SHIFT = 12;
    localparam int PG_W       = ADDR_W - PAGE_SHIFT;
    localparam int CPU_ID_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_USABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ADDR     = 1'd1;

    localparam logic [ADDR_W-1:0] FIRST_USABLE_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] TOP_ADDR_RST     = 40'h00_8800_0000;
    localparam logic [PG_W-1:0]   BASE_PG_RST      = 28'h008_0000;

endpackage

>>> src/pcpfl_free_chk.sv
// Address check and page index computation for a page free request.
module pcpfl_free_chk
    import pcpfl_pkg::*;
#(
    parameter int NUM_PAGES = 32768,
    parameter int IDX_W     = 15
) (
    input  logic [ADDR_W-1:0] page_addr,
    input  logic [ADDR_W-1:0] first_usable,
    input  logic [ADDR_W-1:0] top_addr,
    input  logic [PG_W-1:0]   base_pg,
    output logic              bad,
    output logic [IDX_W-1:0]  idx
);

    logic            misaligned;
    logic            below;
    logic            above;
    logic            out_of_store;
    logic [PG_W-1:0] pg_diff;

    // An aligned page at or above first_usable is also at or above the page base.
    assign misaligned   = |page_addr[PAGE_SHIFT-1:0];
    assign below        = page_addr < first_usable;
    assign above        = page_addr >= top_addr;
    assign pg_diff      = page_addr[ADDR_W-1:PAGE_SHIFT] - base_pg;
    assign out_of_store = pg_diff >= PG_W'(NUM_PAGES);

    assign bad = misaligned | below | above | out_of_store;
    assign idx = pg_diff[IDX_W-1:0];

endmodule

>>> src/per_cpu_page_free_lists.sv
// Top level of the per-CPU page free list allocator.
//
// Keeps 4 KiB physical pages as one last-in-first-out free list per CPU. The
// list heads (page index plus a non-empty flag per CPU) sit in flip-flops; the
// per-page next links sit in a single-port-read, single-port-write memory of
// NUM_PAGES entries with a registered read port. A free request checks the
// address (page aligned, at or above first_usable_addr, below top_addr, index
// below NUM_PAGES), writes the old head into the page's link entry and makes the
// page the new head, with status 1, or status 3 with no change when the
// address is bad. An allocate request pops the requester's own list, or else
// the list of the lowest-numbered CPU that is not empty, via a pop state, as
// the link of the popped page comes back from the link memory in the cycle
// after the head is known; status 2 when every list is empty. Requests are
// handled one at a time; the handshake takes a new request while the previous
// result still waits in the output register. A cpu_id of NUM_CPUS or more
// wraps modulo NUM_CPUS. Stored page indices are relative to the page base
// (first_usable_addr rounded up to a page) at the time of the allocate. Link
// entries are never cleared: only entries that a free has written are read.
// Configuration writes take effect for requests accepted on a later cycle.
`include "per_cpu_page_free_lists_macros.svh"

module per_cpu_page_free_lists
    import pcpfl_pkg::*;
#(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [ADDR_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [CPU_ID_W-1:0]  s_cpu_id,
    input  logic [ADDR_W-1:0]    s_page_addr,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [ADDR_W-1:0]    m_alloc_addr
);

    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CPU_W      = $clog2(NUM_CPUS);
    localparam int WRAP_W     = ((CPU_ID_W > CPU_W) ? CPU_ID_W : CPU_W) + 1;
    localparam int WRAP_STEPS = (1 << CPU_ID_W) / NUM_CPUS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    // Reduce a CPU number modulo NUM_CPUS by repeated subtraction.
    function automatic logic [CPU_W-1:0] cpu_wrap(input logic [CPU_ID_W-1:0] id);
        logic [WRAP_W-1:0] v;
        v = WRAP_W'(id);
        for (int i = 0; i < WRAP_STEPS; i++) begin
            if (v >= WRAP_W'(NUM_CPUS)) begin
                v = v - WRAP_W'(NUM_CPUS);
            end
        end
        return v[CPU_W-1:0];
    endfunction

    // Configuration registers and the derived page base (in pages).
    logic [ADDR_W-1:0] first_usable_reg;
    logic [ADDR_W-1:0] top_addr_reg;
    logic [PG_W-1:0]   base_pg_reg;

    // Control and captured request.
    logic [1:0]          state_reg, state_next;
    logic                req_cmd_reg;
    logic [CPU_W-1:0]    req_cpu_reg;
    logic [ADDR_W-1:0]   req_addr_reg;
    logic [CPU_W-1:0]    src_reg, src_next;
    logic [IDX_W-1:0]    pop_idx_reg, pop_idx_next;

    // List heads.
    logic [IDX_W-1:0]    head_idx_reg  [NUM_CPUS];
    logic [IDX_W-1:0]    head_idx_next [NUM_CPUS];
    logic [NUM_CPUS-1:0] head_valid_reg, head_valid_next;

    // Link memory.
    logic [LINK_W-1:0]   link_mem [NUM_PAGES];
    logic [LINK_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_wr_idx;
    logic [LINK_W-1:0]   mem_wr_data;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_rd_idx;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ADDR_W-1:0]   m_alloc_addr_reg, m_alloc_addr_next;

    logic                out_free;
    logic                out_load;
    logic                chk_bad;
    logic [IDX_W-1:0]    chk_idx;
    logic [CPU_W-1:0]    steal_cpu;
    logic                any_valid;
    logic [CPU_W-1:0]    pick_cpu;
    logic                link_has_next;
    logic [IDX_W-1:0]    link_idx;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_alloc_addr = m_alloc_addr_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign any_valid    = |head_valid_reg;
    assign link_has_next = rd_data_reg[LINK_W-1];
    assign link_idx      = rd_data_reg[IDX_W-1:0];

    pcpfl_free_chk #(
        .NUM_PAGES (NUM_PAGES),
        .IDX_W     (IDX_W)
    ) u_free_chk (
        .page_addr    (req_addr_reg),
        .first_usable (first_usable_reg),
        .top_addr     (top_addr_reg),
        .base_pg      (base_pg_reg),
        .bad          (chk_bad),
        .idx          (chk_idx)
    );

    // Lowest-numbered non-empty list; only used when the requester's own is empty.
    always_comb begin
        steal_cpu = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (head_valid_reg[i]) begin
                steal_cpu = CPU_W'(i);
            end
        end
    end

    assign pick_cpu = head_valid_reg[req_cpu_reg] ? req_cpu_reg : steal_cpu;

    // Request sequencer.
    always_comb begin
        state_next        = state_reg;
        src_next          = src_reg;
        pop_idx_next      = pop_idx_reg;
        head_idx_next     = head_idx_reg;
        head_valid_next   = head_valid_reg;
        mem_we            = 1'b0;
        mem_wr_idx        = chk_idx;
        mem_wr_data       = {head_valid_reg[req_cpu_reg], head_idx_reg[req_cpu_reg]};
        mem_re            = 1'b0;
        mem_rd_idx        = head_idx_reg[pick_cpu];
        out_load          = 1'b0;
        m_status_next     = m_status_reg;
        m_alloc_addr_next = m_alloc_addr_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (req_cmd_reg == CMD_FREE) begin
                    if (out_free) begin
                        out_load          = 1'b1;
                        m_alloc_addr_next = '0;
                        state_next        = S_IDLE;
                        if (chk_bad) begin
                            m_status_next = STATUS_BAD;
                        end else begin
                            // Push: old head becomes this page's link.
                            mem_we                     = 1'b1;
                            head_idx_next[req_cpu_reg] = chk_idx;
                            head_valid_next[req_cpu_reg] = 1'b1;
                            m_status_next              = STATUS_FREED;
                        end
                    end
                end else if (any_valid) begin
                    // Fetch the link of the head page being popped.
                    mem_re       = 1'b1;
                    src_next     = pick_cpu;
                    pop_idx_next = head_idx_reg[pick_cpu];
                    state_next   = S_POP;
                end else if (out_free) begin
                    out_load          = 1'b1;
                    m_status_next     = STATUS_OOM;
                    m_alloc_addr_next = '0;
                    state_next        = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    head_valid_next[src_reg] = link_has_next;
                    head_idx_next[src_reg]   = link_has_next ? link_idx : '0;
                    m_status_next            = STATUS_ALLOC;
                    m_alloc_addr_next        = {base_pg_reg + PG_W'(pop_idx_reg),
                                                {PAGE_SHIFT{1'b0}}};
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Configuration registers; the page base follows first_usable in the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_usable_reg <= FIRST_USABLE_RST;
            top_addr_reg     <= TOP_ADDR_RST;
            base_pg_reg      <= BASE_PG_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_FIRST_USABLE: first_usable_reg <= cfg_wdata;
                    REG_TOP_ADDR:     top_addr_reg     <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            base_pg_reg <= first_usable_reg[ADDR_W-1:PAGE_SHIFT]
                         + PG_W'(|first_usable_reg[PAGE_SHIFT-1:0]);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                head_idx_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            head_idx_reg   <= head_idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers: capture on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_cmd_reg  <= s_cmd;
            req_cpu_reg  <= cpu_wrap(s_cpu_id);
            req_addr_reg <= s_page_addr;
        end
        src_reg          <= src_next;
        pop_idx_reg      <= pop_idx_next;
        m_status_reg     <= m_status_next;
        m_alloc_addr_reg <= m_alloc_addr_next;
    end

    // Link memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_wr_idx] <= mem_wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= link_mem[mem_rd_idx];
        end
    end

    `PCPFL_ASSERT(a_accept_to_exec, (s_valid && s_ready) |=> (state_reg == S_EXEC), "accepted request did not start execution")
    `PCPFL_ASSERT(a_idle_heads_hold, (state_reg == S_IDLE) |=> $stable(head_valid_reg), "list flags changed while no request was active")
    `PCPFL_ASSERT(a_pop_only_alloc, (state_reg == S_POP) |-> (req_cmd_reg == CMD_ALLOC), "pop stage entered for a free request")
    `PCPFL_ASSERT(a_oom_when_empty, (state_reg == S_EXEC && req_cmd_reg == CMD_ALLOC && !any_valid && out_free) |=> (m_valid && m_status == STATUS_OOM), "empty lists did not report out of memory")
    `PCPFL_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == S_IDLE && !m_valid_reg), "reset did not clear the sequencer")

endmodule

>>> test/per_cpu_page_free_lists_test.sv
// Self-checking testbench for the per-CPU page free list allocator.
`timescale 1ns / 100ps

module per_cpu_page_free_lists_test;
    import pcpfl_pkg::*;

    localparam int N_CPUS       = 8;
    localparam int N_PAGES      = 32768;
    localparam int PAGE_BYTES   = 4096;
    localparam int PG_IDX_W     = $clog2(N_PAGES);
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [ADDR_W:0]   PAGE_LOW = (1 << PAGE_SHIFT) - 1;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    // One request as offered on the input channel.
    typedef struct packed {
        logic                cmd;
        logic [CPU_ID_W-1:0] cpu;
        logic [ADDR_W-1:0]   addr;
    } page_req_t;

    // One outcome as returned on the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } page_outcome_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx     = REG_FIRST_USABLE;
    logic [ADDR_W-1:0]    cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_cmd       = CMD_ALLOC;
    logic [CPU_ID_W-1:0]  s_cpu_id    = '0;
    logic [ADDR_W-1:0]    s_page_addr = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [ADDR_W-1:0]    m_alloc_addr;

    per_cpu_page_free_lists #(
        .NUM_CPUS  (N_CPUS),
        .NUM_PAGES (N_PAGES)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_cpu_id     (s_cpu_id),
        .s_page_addr  (s_page_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_alloc_addr (m_alloc_addr)
    );

    // Requests waiting to go out, and outcomes waiting to come back.
    page_req_t     page_reqs[$];
    page_outcome_t expected_outcomes[$];

    // Mirror of the allocator: configuration, list heads and per-page links.
    logic [ADDR_W-1:0]   first_usable_q = FIRST_USABLE_RST;
    logic [ADDR_W-1:0]   top_addr_q     = TOP_ADDR_RST;
    bit [PG_IDX_W-1:0]   head_pg   [N_CPUS];
    bit                  head_live [N_CPUS];
    bit [PG_IDX_W-1:0]   link_pg   [N_PAGES];
    bit                  link_live [N_PAGES];

    // Stimulus-side view of the configuration and of pages already handed out.
    logic [ADDR_W-1:0]   gen_first = FIRST_USABLE_RST;
    logic [ADDR_W-1:0]   gen_top   = TOP_ADDR_RST;
    bit                  pg_taken [N_PAGES];
    int unsigned         fresh_pg  = 0;
    int unsigned         queued_cnt = 0;

    // Flow control knobs; the first three are set by the sequence at falling edges.
    bit                  calm        = 1'b0;
    bit                  sender_hold = 1'b0;
    int unsigned         hold_off_len = 0;
    int unsigned         tx_gap = 0;
    int unsigned         rx_gap = 0;

    int unsigned         mismatch_cnt = 0;
    int unsigned         cycle_cnt    = 0;
    int unsigned         n_allocs = 0, n_steals = 0, n_oom = 0, n_freed = 0, n_rejected = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Round the first usable address up to a page; one bit wider so that it can
    // reach past the top of the address space.
    function automatic logic [ADDR_W:0] page_base_of(logic [ADDR_W-1:0] first);
        return ({1'b0, first} + PAGE_LOW) & ~PAGE_LOW;
    endfunction

    // Work out the outcome of one accepted request and update the mirror.
    function automatic page_outcome_t serve_page_request(page_req_t r);
        page_outcome_t       o;
        logic [ADDR_W:0]     base;
        logic [ADDR_W:0]     off;
        logic [ADDR_W:0]     sum;
        logic [PG_IDX_W-1:0] pg;
        int unsigned         cpu;
        int unsigned         src;
        bit                  found;
        o.status = STATUS_BAD;
        o.addr   = '0;
        base     = page_base_of(first_usable_q);
        cpu      = r.cpu % N_CPUS;
        if (r.cmd == CMD_FREE) begin
            off = {1'b0, r.addr} - base;
            if (r.addr[PAGE_SHIFT-1:0] == '0 && r.addr >= first_usable_q &&
                r.addr < top_addr_q && {1'b0, r.addr} >= base &&
                (off >> PAGE_SHIFT) < N_PAGES) begin
                // Push: the old head becomes this page's successor.
                pg             = off[PAGE_SHIFT +: PG_IDX_W];
                link_pg[pg]    = head_pg[cpu];
                link_live[pg]  = head_live[cpu];
                head_pg[cpu]   = pg;
                head_live[cpu] = 1'b1;
                o.status       = STATUS_FREED;
                n_freed++;
            end else begin
                n_rejected++;
            end
        end else begin
            // Own list first, else the lowest-numbered CPU holding a page.
            src   = cpu;
            found = head_live[cpu];
            for (int c = 0; c < N_CPUS; c++) begin
                if (!found && head_live[c]) begin
                    src   = c;
                    found = 1'b1;
                end
            end
            if (!found) begin
                o.status = STATUS_OOM;
                n_oom++;
            end else begin
                if (src != cpu)
                    n_steals++;
                pg = head_pg[src];
                if (link_live[pg]) begin
                    head_pg[src] = link_pg[pg];
                end else begin
                    head_live[src] = 1'b0;
                    head_pg[src]   = '0;
                end
                off      = pg;
                sum      = base + (off << PAGE_SHIFT);
                o.status = STATUS_ALLOC;
                o.addr   = sum[ADDR_W-1:0];
                n_allocs++;
            end
        end
        return o;
    endfunction

    // Byte address of page index pg under the stimulus-side configuration.
    function automatic logic [ADDR_W-1:0] page_addr_at(int unsigned pg);
        logic [ADDR_W:0] off;
        logic [ADDR_W:0] a;
        off = pg;
        a   = page_base_of(gen_first) + (off << PAGE_SHIFT);
        return a[ADDR_W-1:0];
    endfunction

    // Pick a page that has never been freed, so that random traffic builds no
    // loops; lean toward the top of the window now and then.
    function automatic bit pick_fresh_addr(output logic [ADDR_W-1:0] addr);
        logic [ADDR_W:0] base;
        logic [63:0]     span;
        int unsigned     win;
        int unsigned     pg;
        bit              hit;
        base = page_base_of(gen_first);
        win  = 0;
        hit  = 1'b0;
        pg   = 0;
        addr = '0;
        if ({1'b0, gen_top} > base) begin
            span = ({1'b0, gen_top} - base + PAGE_LOW) >> PAGE_SHIFT;
            win  = (span > N_PAGES) ? N_PAGES : span;
        end
        if (win > 0 && $urandom_range(0, 4) == 0) begin
            pg  = win - 1 - $urandom_range(0, (win > 8) ? 7 : win - 1);
            hit = !pg_taken[pg];
        end
        if (!hit) begin
            while (fresh_pg < win && pg_taken[fresh_pg])
                fresh_pg++;
            if (fresh_pg < win) begin
                pg  = fresh_pg;
                hit = 1'b1;
            end
        end
        if (hit) begin
            pg_taken[pg] = 1'b1;
            addr         = page_addr_at(pg);
        end
        return hit;
    endfunction

    // An address that the free check should turn away, of a random kind.
    function automatic logic [ADDR_W-1:0] pick_bad_addr();
        logic [63:0] a;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: a = page_addr_at($urandom_range(0, 255)) | $urandom_range(1, PAGE_BYTES - 1);
            1: a = (gen_first != 0) ? (rnd % gen_first) & ~PAGE_LOW : rnd;
            2: a = ((gen_top + PAGE_LOW) & ~PAGE_LOW) + ($urandom_range(0, 3) << PAGE_SHIFT);
            3: a = page_base_of(gen_first) + ((N_PAGES + $urandom_range(0, 15)) << PAGE_SHIFT);
            default: a = rnd;
        endcase
        // Drop anything that would wrap back into the address space.
        if (a[63:ADDR_W] != 0)
            a = rnd | 64'd1;
        return a[ADDR_W-1:0];
    endfunction

    task automatic push_req(input logic cmd, input logic [CPU_ID_W-1:0] cpu,
                            input logic [ADDR_W-1:0] addr);
        page_req_t r;
        r.cmd  = cmd;
        r.cpu  = cpu;
        r.addr = addr;
        page_reqs.push_back(r);
        queued_cnt++;
    endtask

    task automatic queue_free(input logic [CPU_ID_W-1:0] cpu);
        logic [ADDR_W-1:0] a;
        if (!pick_fresh_addr(a))
            a = pick_bad_addr();
        push_req(CMD_FREE, cpu, a);
    endtask

    // Random traffic: mostly fill-then-drain bursts, some single requests and
    // some noise (rejected frees, allocations on possibly empty lists).
    task automatic queue_random_traffic(input int unsigned n);
        int unsigned         start;
        int unsigned         k;
        int unsigned         pick;
        logic [CPU_ID_W-1:0] c;
        start = queued_cnt;
        while (queued_cnt - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                k = $urandom_range(1, 6);
                c = $urandom;
                repeat (k) begin
                    if ($urandom_range(0, 3) == 0)
                        c = $urandom;
                    queue_free(c);
                end
                repeat (k + $urandom_range(0, 2))
                    push_req(CMD_ALLOC, $urandom, {$urandom, $urandom});
            end else if (pick < 85) begin
                if ($urandom_range(0, 1))
                    queue_free($urandom);
                else
                    push_req(CMD_ALLOC, $urandom, {$urandom, $urandom});
            end else if ($urandom_range(0, 1)) begin
                push_req(CMD_FREE, $urandom, pick_bad_addr());
            end else begin
                push_req(CMD_ALLOC, $urandom, {$urandom, $urandom});
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Reprogram both bounds; call only with nothing in flight.
    task automatic set_window(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] top);
        write_reg(REG_FIRST_USABLE, first);
        write_reg(REG_TOP_ADDR, top);
        gen_first = first;
        gen_top   = top;
        @(negedge aclk);
    endtask

    task automatic wait_until_drained();
        while (page_reqs.size() != 0 || s_valid || expected_outcomes.size() != 0)
            @(negedge aclk);
    endtask

    task automatic wait_for_queue_below(input int unsigned n);
        while (page_reqs.size() >= n)
            @(negedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input page_outcome_t want);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s: expected status %0d addr %h, got status %0d addr %h",
                     $time, what, want.status, want.addr, m_status, m_alloc_addr);
    endtask

    // Request driver: hold each request until taken, idle in short bursts.
    always @(posedge aclk) begin : drive_requests
        page_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tx_gap > 0) begin
                tx_gap  <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (page_reqs.size() == 0 || sender_hold) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                tx_gap  <= $urandom_range(0, 2);
                s_valid <= 1'b0;
            end else begin
                req          = page_reqs.pop_front();
                s_valid     <= 1'b1;
                s_cmd       <= req.cmd;
                s_cpu_id    <= req.cpu;
                s_page_addr <= req.addr;
            end
        end
    end

    // Result monitor: check what comes out, then predict what each accepted
    // request will return, then track register writes. Keep that order so a
    // write only affects requests taken on a later edge.
    always @(posedge aclk) begin : watch_results
        page_outcome_t want;
        page_req_t     taken;
        if (!aresetn) begin
            m_ready        <= 1'b0;
            first_usable_q  = FIRST_USABLE_RST;
            top_addr_q      = TOP_ADDR_RST;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    want = '0;
                    flag_mismatch("result with no request outstanding", want);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (want.status !== m_status)
                        flag_mismatch("status differs", want);
                    else if (want.addr !== m_alloc_addr)
                        flag_mismatch("page address differs", want);
                end
            end
            if (s_valid && s_ready) begin
                taken.cmd  = s_cmd;
                taken.cpu  = s_cpu_id;
                taken.addr = s_page_addr;
                expected_outcomes.push_back(serve_page_request(taken));
            end
            if (cfg_we) begin
                if (cfg_idx == REG_FIRST_USABLE)
                    first_usable_q = cfg_wdata;
                else if (cfg_idx == REG_TOP_ADDR)
                    top_addr_q = cfg_wdata;
            end
            // Backpressure: a long hold-off when asked, else short random stalls.
            if (hold_off_len > 0) begin
                hold_off_len <= hold_off_len - 1;
                m_ready      <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                rx_gap  <= $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: abort a run that stops making progress.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("timed out after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests under the reset bounds.
        pg_taken[0]         = 1'b1;
        pg_taken[1]         = 1'b1;
        pg_taken[2]         = 1'b1;
        pg_taken[3]         = 1'b1;
        pg_taken[N_PAGES-1] = 1'b1;
        push_req(CMD_ALLOC, 0, '0);                             // all lists empty
        push_req(CMD_ALLOC, 7, ADDR_MAX);
        push_req(CMD_FREE, 0, page_addr_at(0));                 // lowest page
        push_req(CMD_FREE, 7, page_addr_at(N_PAGES - 1));       // last index of the store
        push_req(CMD_FREE, 1, TOP_ADDR_RST);                    // right at the top bound
        push_req(CMD_FREE, 1, FIRST_USABLE_RST - PAGE_BYTES);   // just below first usable
        push_req(CMD_FREE, 1, page_addr_at(5) | 40'h801);       // not page aligned
        push_req(CMD_FREE, 6, '0);
        push_req(CMD_FREE, 3, ADDR_MAX & ~40'hFFF);             // far above the top
        push_req(CMD_ALLOC, 7, '0);                             // own list
        push_req(CMD_ALLOC, 3, '0);                             // steal from CPU 0
        push_req(CMD_ALLOC, 0, '0);                             // empty again
        // Double free: the page links to itself and the list never runs dry.
        push_req(CMD_FREE, 2, page_addr_at(1));
        push_req(CMD_FREE, 2, page_addr_at(1));
        push_req(CMD_ALLOC, 2, '0);
        push_req(CMD_ALLOC, 6, '0);
        // Free it once more onto an empty CPU to cut the loop, then drain both.
        push_req(CMD_FREE, 5, page_addr_at(1));
        push_req(CMD_ALLOC, 2, '0);
        push_req(CMD_ALLOC, 5, '0);
        push_req(CMD_ALLOC, 4, '0);
        // Two donors: the lower-numbered CPU gives first.
        push_req(CMD_FREE, 6, page_addr_at(2));
        push_req(CMD_FREE, 4, page_addr_at(3));
        push_req(CMD_ALLOC, 1, '0);
        push_req(CMD_ALLOC, 1, '0);

        // Random traffic under the reset bounds, with both pressure cases.
        queue_random_traffic(200);
        wait_for_queue_below(150);
        hold_off_len = 150;                 // receiver holds off, sender keeps going
        wait_for_queue_below(60);
        sender_hold = 1'b1;                 // sender pauses until everything is back
        while (s_valid || expected_outcomes.size() != 0)
            @(negedge aclk);
        sender_hold = 1'b0;
        wait_until_drained();

        // Whole address space: the store size becomes the only upper limit.
        set_window('0, ADDR_MAX);
        queue_random_traffic(150);
        wait_until_drained();

        // Nothing can be freed; allocations drain the lists to out of memory
        // with the page base wrapped past the top of the address space.
        set_window(ADDR_MAX, '0);
        queue_random_traffic(100);
        wait_until_drained();

        // Unaligned first usable address and a small window above it.
        gen_first = 40'h03_0000_0000 + $urandom_range(1, 32'h3FFF_FFFF);
        set_window(gen_first,
                   page_base_of(gen_first) + (1024 * PAGE_BYTES) + $urandom_range(1, PAGE_BYTES - 1));
        queue_random_traffic(200);
        wait_until_drained();

        // Back to the reset bounds, no idling on either side.
        calm = 1'b1;
        set_window(FIRST_USABLE_RST, TOP_ADDR_RST);
        queue_random_traffic(150);
        wait_until_drained();
        repeat (20) @(posedge aclk);

        if (expected_outcomes.size() != 0) begin
            $display("%0d results never came back", expected_outcomes.size());
            mismatch_cnt += expected_outcomes.size();
        end
        $display("covered %0d requests over five bound settings: %0d pages handed out, %0d stolen",
                 queued_cnt, n_allocs, n_steals);
        $display("  %0d out of memory, %0d pages freed, %0d frees turned away, %0d mismatches",
                 n_oom, n_freed, n_rejected, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
